// ===== rtl/battery_runtime_estimator_macros.svh =====
// Assertion macros shared by the battery runtime estimator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BATTERY_RUNTIME_ESTIMATOR_MACROS_SVH
`define BATTERY_RUNTIME_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRTE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRTE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/brte_pkg.sv =====
// Package for the battery runtime estimator: widths, reset values,
// register indexes, FSM state and divider control/status types. No dependencies.
`timescale 1ns / 1ps

package brte_pkg;

  localparam int unsigned LevelW   = 7;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RateW    = 18;
  localparam int unsigned SecW     = 26;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivCntW  = 5;

  localparam logic [LevelW-1:0] LEVEL_FULL = 7'd100;

  localparam logic [RateW-1:0] RST_DEFAULT_RATE = 18'd6048;
  localparam logic [RateW-1:0] RST_MIN_RATE     = 18'd60;
  localparam logic [RateW-1:0] RST_MAX_RATE     = 18'd200000;

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_RATE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RATE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RATE     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SMOOTH,
    ST_OUT
  } brte_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/brte_if.sv =====
// Valid/ready channel interfaces: reading input, result output, config write.
// Depends on brte_pkg.
`timescale 1ns / 1ps

interface brte_in_if;
  logic                           valid;
  logic                           ready;
  logic [brte_pkg::LevelW-1:0]    level_percent;
  logic                           charging_flag;
  logic                           plugged_flag;
  logic [brte_pkg::TimeW-1:0]     timestamp_seconds;

  modport source (output valid, level_percent, charging_flag, plugged_flag,
                  timestamp_seconds, input ready);
  modport sink   (input valid, level_percent, charging_flag, plugged_flag,
                  timestamp_seconds, output ready);
endinterface

interface brte_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [brte_pkg::SecW-1:0]  seconds_remaining;
  logic [brte_pkg::RateW-1:0]        rate_estimate;

  modport source (output valid, seconds_remaining, rate_estimate, input ready);
  modport sink   (input valid, seconds_remaining, rate_estimate, output ready);
endinterface

interface brte_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [brte_pkg::CfgIdxW-1:0]  index;
  logic [brte_pkg::RateW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/brte_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle: 32-bit time span
// over 7-bit percent drop. Depends on brte_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "battery_runtime_estimator_macros.svh"

module brte_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brte_pkg::div_ctrl_t          ctrl_i,
  input  logic [brte_pkg::TimeW-1:0]   dividend_i,
  input  logic [brte_pkg::LevelW-1:0]  divisor_i,
  output brte_pkg::div_stat_t          stat_o,
  output logic [brte_pkg::TimeW-1:0]   quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [brte_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [brte_pkg::TimeW-1:0]    qd_q, qd_d;
  logic [brte_pkg::LevelW-1:0]   rem_q, rem_d;
  logic [brte_pkg::LevelW-1:0]   dvs_q, dvs_d;
  logic [brte_pkg::LevelW:0]     trial;
  logic [brte_pkg::LevelW:0]     diff;

  // shift next dividend bit into the partial remainder, then trial subtract
  assign trial = {rem_q, qd_q[brte_pkg::TimeW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qd_d   = qd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      qd_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[brte_pkg::LevelW-1:0];
        qd_d  = {qd_q[brte_pkg::TimeW-2:0], 1'b1};
      end else begin
        rem_d = trial[brte_pkg::LevelW-1:0];
        qd_d  = {qd_q[brte_pkg::TimeW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {brte_pkg::DivCntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q  <= qd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = qd_q;

  `BRTE_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q, "div done while busy")
  `BRTE_ASSERT_NXT(a_start_busy, clk_i, rst_ni, ctrl_i.start && !busy_q, busy_q,
                   "div start did not raise busy")
  `BRTE_ASSERT_NOW(a_rem_bound, clk_i, rst_ni, busy_q && (dvs_q != '0), rem_q < dvs_q,
                   "partial remainder not below divisor")
  `BRTE_ASSERT_NXT(a_done_follows, clk_i, rst_ni,
                   busy_q && (cnt_q == {brte_pkg::DivCntW{1'b1}}), done_q,
                   "div done missing after last step")

endmodule

// ===== rtl/battery_runtime_estimator.sv =====
// Battery runtime estimator top level: sequencer, baseline/rate state,
// config registers and result register. Depends on brte_pkg, brte_if, brte_div.
`timescale 1ns / 1ps
`include "battery_runtime_estimator_macros.svh"

// Channel  Dir  Beat carries
// -------  ---  ----------------------------------------------------------
// cfg_i    in   index (2b), data (18b): default_rate / min_rate / max_rate
// in_i     in   level_percent, charging_flag, plugged_flag, timestamp_seconds
// res_o    out  seconds_remaining (26b signed), rate_estimate (18b)
//
// A reading that falls in level with time advanced passes from accept
// through 32 divider steps (one quotient bit per cycle in brte_div), the
// clamp into the sample register, smoothing and the result load; any other
// reading goes straight to the result load. in_i.ready is high only while
// the sequencer is idle. A finished result waits in the res_o register; the
// next beat is taken meanwhile, and the sequencer holds in its result state
// while that register is still full. cfg_i is always ready. Reset is
// asynchronous, active low, and needs no clearing pass.

module battery_runtime_estimator (
  input  logic          clk_i,
  input  logic          rst_ni,
  brte_cfg_if.sink      cfg_i,
  brte_in_if.sink       in_i,
  brte_out_if.source    res_o
);

  brte_pkg::brte_state_e state_q, state_d;

  // config registers
  logic [brte_pkg::RateW-1:0]   def_rate_q, def_rate_d;
  logic [brte_pkg::RateW-1:0]   min_rate_q, min_rate_d;
  logic [brte_pkg::RateW-1:0]   max_rate_q, max_rate_d;

  // estimator state
  logic [brte_pkg::LevelW-1:0]  base_level_q, base_level_d;
  logic [brte_pkg::TimeW-1:0]   base_time_q, base_time_d;
  logic                         base_valid_q, base_valid_d;
  logic [brte_pkg::RateW-1:0]   rate_q, rate_d;

  // current reading, held for the length of the item
  logic [brte_pkg::LevelW-1:0]  cur_level_q, cur_level_d;
  logic [brte_pkg::TimeW-1:0]   cur_time_q, cur_time_d;
  logic                         powered_q, powered_d;
  logic [brte_pkg::RateW-1:0]   sample_q, sample_d;

  // result register
  logic                         res_valid_q, res_valid_d;
  logic [brte_pkg::SecW-1:0]    res_sec_q, res_sec_d;
  logic [brte_pkg::RateW-1:0]   res_rate_q, res_rate_d;

  // divider hookup
  brte_pkg::div_ctrl_t          div_ctrl;
  brte_pkg::div_stat_t          div_stat;
  logic [brte_pkg::TimeW-1:0]   div_dividend;
  logic [brte_pkg::LevelW-1:0]  div_divisor;
  logic [brte_pkg::TimeW-1:0]   div_quot;

  logic [brte_pkg::LevelW-1:0]  in_level;
  logic                         in_powered;
  logic [brte_pkg::TimeW-1:0]   clamp_lo;
  logic [brte_pkg::TimeW-1:0]   clamp_hi;
  logic [brte_pkg::RateW+1:0]   smooth_sum;
  logic [brte_pkg::LevelW+brte_pkg::RateW-1:0] product;

  // levels above full read as full
  assign in_level   = (in_i.level_percent > brte_pkg::LEVEL_FULL) ?
                      brte_pkg::LEVEL_FULL : in_i.level_percent;
  assign in_powered = in_i.charging_flag | in_i.plugged_flag;

  assign div_dividend = in_i.timestamp_seconds - base_time_q;
  assign div_divisor  = base_level_q - in_level;

  // min clamp first, then max, so max wins on crossed limits
  assign clamp_lo = (div_quot < {{(brte_pkg::TimeW-brte_pkg::RateW){1'b0}}, min_rate_q}) ?
                    {{(brte_pkg::TimeW-brte_pkg::RateW){1'b0}}, min_rate_q} : div_quot;
  assign clamp_hi = (clamp_lo > {{(brte_pkg::TimeW-brte_pkg::RateW){1'b0}}, max_rate_q}) ?
                    {{(brte_pkg::TimeW-brte_pkg::RateW){1'b0}}, max_rate_q} : clamp_lo;

  // 3*rate + sample, then /4
  assign smooth_sum = {2'b00, rate_q} + {1'b0, rate_q, 1'b0} + {2'b00, sample_q};

  assign product = cur_level_q * rate_q;

  brte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    def_rate_d   = def_rate_q;
    min_rate_d   = min_rate_q;
    max_rate_d   = max_rate_q;
    base_level_d = base_level_q;
    base_time_d  = base_time_q;
    base_valid_d = base_valid_q;
    rate_d       = rate_q;
    cur_level_d  = cur_level_q;
    cur_time_d   = cur_time_q;
    powered_d    = powered_q;
    sample_d     = sample_q;
    res_valid_d  = res_valid_q;
    res_sec_d    = res_sec_q;
    res_rate_d   = res_rate_q;
    div_ctrl.start = 1'b0;

    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end

    // the user must send config beats only while the sequencer is idle; the block does not enforce it
    if (cfg_i.valid) begin
      case (cfg_i.index)
        brte_pkg::CFG_DEFAULT_RATE: begin
          def_rate_d = cfg_i.data;
          if (!base_valid_q) begin
            rate_d = cfg_i.data;
          end
        end
        brte_pkg::CFG_MIN_RATE: min_rate_d = cfg_i.data;
        brte_pkg::CFG_MAX_RATE: max_rate_d = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      brte_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          cur_level_d = in_level;
          cur_time_d  = in_i.timestamp_seconds;
          powered_d   = in_powered;
          state_d     = brte_pkg::ST_OUT;
          if (!base_valid_q || in_powered || (in_level > base_level_q)) begin
            base_level_d = in_level;
            base_time_d  = in_i.timestamp_seconds;
            base_valid_d = 1'b1;
          end else if (in_level < base_level_q) begin
            if (in_i.timestamp_seconds > base_time_q) begin
              div_ctrl.start = 1'b1;
              state_d        = brte_pkg::ST_DIV;
            end else begin
              // no time elapsed: move baseline, keep rate
              base_level_d = in_level;
              base_time_d  = in_i.timestamp_seconds;
            end
          end
        end
      end
      brte_pkg::ST_DIV: begin
        if (div_stat.done) begin
          sample_d = clamp_hi[brte_pkg::RateW-1:0];
          state_d  = brte_pkg::ST_SMOOTH;
        end
      end
      brte_pkg::ST_SMOOTH: begin
        rate_d       = smooth_sum[brte_pkg::RateW+1:2];
        base_level_d = cur_level_q;
        base_time_d  = cur_time_q;
        state_d      = brte_pkg::ST_OUT;
      end
      brte_pkg::ST_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_rate_d  = rate_q;
          if (powered_q || (rate_q == '0)) begin
            res_sec_d = '1;
          end else begin
            res_sec_d = {1'b0, product};
          end
          state_d = brte_pkg::ST_IDLE;
        end
      end
      default: state_d = brte_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brte_pkg::ST_IDLE;
      def_rate_q   <= brte_pkg::RST_DEFAULT_RATE;
      min_rate_q   <= brte_pkg::RST_MIN_RATE;
      max_rate_q   <= brte_pkg::RST_MAX_RATE;
      base_level_q <= '0;
      base_time_q  <= '0;
      base_valid_q <= 1'b0;
      rate_q       <= brte_pkg::RST_DEFAULT_RATE;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      def_rate_q   <= def_rate_d;
      min_rate_q   <= min_rate_d;
      max_rate_q   <= max_rate_d;
      base_level_q <= base_level_d;
      base_time_q  <= base_time_d;
      base_valid_q <= base_valid_d;
      rate_q       <= rate_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    cur_level_q <= cur_level_d;
    cur_time_q  <= cur_time_d;
    powered_q   <= powered_d;
    sample_q    <= sample_d;
    res_sec_q   <= res_sec_d;
    res_rate_q  <= res_rate_d;
  end

  assign cfg_i.ready             = 1'b1;
  assign in_i.ready              = (state_q == brte_pkg::ST_IDLE);
  assign res_o.valid             = res_valid_q;
  assign res_o.seconds_remaining = res_sec_q;
  assign res_o.rate_estimate     = res_rate_q;

  `BRTE_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_i.valid && in_i.ready,
                   state_q != brte_pkg::ST_IDLE, "sequencer stayed idle after a beat")
  `BRTE_ASSERT_NOW(a_div_tracks, clk_i, rst_ni, state_q == brte_pkg::ST_DIV,
                   div_stat.busy || div_stat.done, "divide state without divider activity")
  `BRTE_ASSERT_NOW(a_idle_div_free, clk_i, rst_ni, state_q == brte_pkg::ST_IDLE,
                   !div_stat.busy, "divider busy while sequencer idle")
  `BRTE_ASSERT_NXT(a_smooth_valid, clk_i, rst_ni, state_q == brte_pkg::ST_SMOOTH,
                   base_valid_q && (state_q == brte_pkg::ST_OUT),
                   "smoothing step did not lead to result")

endmodule
